>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL. They compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// A condition that, once seen, implies another one at the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/lkc_pkg.sv
package lkc_pkg;

    // Field widths.
    localparam int KEY_W = 32;
    localparam int CNT_W = 5;

    // Default number of cells and the capacity after reset.
    localparam int             DEF_MAX_ENTRIES = 16;
    localparam logic [CNT_W-1:0] CAP_RESET     = 5'd16;

    // Largest capacity the configuration register can express.
    localparam int CAP_FIELD_MAX = (1 << CNT_W) - 1;

    // What one cell hands to the next one down the row.
    typedef struct packed {
        logic                    valid;
        logic                    found;
        logic signed [KEY_W-1:0] key;
    } t_link;

endpackage

>>> sv/lkc_req_if.sv
// Access channel: one key per transfer.
interface lkc_req_if;
    logic                             valid;
    logic                             ready;
    logic signed [lkc_pkg::KEY_W-1:0] key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

>>> sv/lkc_rsp_if.sv
// Result channel: hit flag and occupancy per transfer.
interface lkc_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic [lkc_pkg::CNT_W-1:0] occupancy;

    modport source (output valid, output hit, output occupancy, input ready);
    modport sink   (input valid, input hit, input occupancy, output ready);
endinterface

>>> sv/lkc_cell.sv
// One entry of the recency row. Position in the row is the recency rank:
// the cell nearest the input holds the most recently used key.
module lkc_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_keep,
    input  logic signed [lkc_pkg::KEY_W-1:0] i_key,
    input  lkc_pkg::t_link i_link,
    output lkc_pkg::t_link o_link
);

    logic                             r_valid;
    logic                             n_valid;
    logic signed [lkc_pkg::KEY_W-1:0] r_key;
    logic signed [lkc_pkg::KEY_W-1:0] n_key;
    logic                             w_match;
    logic                             w_shift;

    // Compare against the broadcast key; only a valid entry can match.
    assign w_match = r_valid && (r_key == i_key);

    // A cell shifts unless the hit lies nearer the input than this cell.
    assign w_shift = i_en && !i_link.found;

    // Take the neighbor's entry on a shift; the cell past capacity drops it.
    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        if (w_shift) begin
            n_valid = i_link.valid && i_keep;
            n_key   = i_link.key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    // Pass this entry and the running hit flag down the row.
    assign o_link.valid = r_valid;
    assign o_link.found = i_link.found || w_match;
    assign o_link.key   = r_key;

endmodule

>>> sv/lru_key_cache.sv
// Fully associative LRU key store built as a row of cells ordered by recency.
// For each access the key is compared in every cell at once, the
// hit flag ripples down the row, and on the same clock edge the cells from
// the input through the hit cell (all cells on a miss) shift one place down
// while the key enters the first cell. The result is held in an output
// register, so a new key is taken in every cycle the result side keeps up;
// the ripple of the hit flag through MAX_ENTRIES cells sets the cycle time.
// Capacity values of zero act as one, values above MAX_ENTRIES act as
// MAX_ENTRIES, and a capacity write is ignored unless the store is empty.
// Reset leaves the store empty with capacity 16.
`include "assert_macros.svh"

module lru_key_cache #(
    parameter int MAX_ENTRIES = lkc_pkg::DEF_MAX_ENTRIES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lkc_pkg::CNT_W-1:0] i_cfg_wdata,
    lkc_req_if.sink                   i_req,
    lkc_rsp_if.source                 o_rsp
);

    localparam int CAP_LIM = (MAX_ENTRIES > lkc_pkg::CAP_FIELD_MAX) ?
                             lkc_pkg::CAP_FIELD_MAX : MAX_ENTRIES;
    localparam logic [lkc_pkg::CNT_W-1:0] CAP_LIM_V = lkc_pkg::CNT_W'(CAP_LIM);

    logic [lkc_pkg::CNT_W-1:0] r_cap;
    logic [lkc_pkg::CNT_W-1:0] w_eff_cap;
    logic [lkc_pkg::CNT_W-1:0] r_count;
    logic [lkc_pkg::CNT_W-1:0] n_count;
    logic                      r_out_valid;
    logic                      r_hit;
    logic [lkc_pkg::CNT_W-1:0] r_occ;
    logic                      w_accept;
    logic                      w_hit;
    logic [MAX_ENTRIES-1:0]    w_keep;
    logic [MAX_ENTRIES-1:0]    w_valids;
    lkc_pkg::t_link            w_link [MAX_ENTRIES+1];

    // Capacity in use after clamping.
    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = lkc_pkg::CNT_W'(1);
        end else if (r_cap > CAP_LIM_V) begin
            w_eff_cap = CAP_LIM_V;
        end else begin
            w_eff_cap = r_cap;
        end
    end

    // Capacity register, writable only while the store is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lkc_pkg::CAP_RESET;
        end else if (i_cfg_we && (r_count == '0)) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // Take a key whenever the result register is free or being emptied.
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    // The head of the row sees the incoming key as its upstream entry.
    assign w_link[0].valid = 1'b1;
    assign w_link[0].found = 1'b0;
    assign w_link[0].key   = i_req.key;

    // Row of cells; a cell at or past the capacity never holds an entry.
    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        assign w_keep[i] = (i < CAP_LIM) ? (lkc_pkg::CNT_W'(i) < w_eff_cap) : 1'b0;

        lkc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_accept),
            .i_keep  (w_keep[i]),
            .i_key   (i_req.key),
            .i_link  (w_link[i]),
            .o_link  (w_link[i+1])
        );

        assign w_valids[i] = w_link[i+1].valid;
    end

    assign w_hit = w_link[MAX_ENTRIES].found;

    // Occupancy grows on a miss until the capacity is reached.
    always_comb begin
        n_count = r_count;
        if (!w_hit && (r_count < w_eff_cap)) begin
            n_count = r_count + lkc_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    // Result register, loaded on each accepted key and cleared on transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit <= w_hit;
            r_occ <= n_count;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.hit       = r_hit;
    assign o_rsp.occupancy = r_occ;

    // The fill count matches the valid cells and never passes the capacity.
    `ASSERT_ALWAYS(a_count_matches_cells, i_clk, i_rst_n,
                   $countones(w_valids) == 32'(r_count))
    `ASSERT_ALWAYS(a_count_in_capacity, i_clk, i_rst_n, r_count <= w_eff_cap)
    // A miss below capacity adds exactly one entry.
    `ASSERT_NEXT(a_miss_grows, i_clk, i_rst_n,
                 w_accept && !w_hit && (r_count < w_eff_cap),
                 r_count == $past(r_count) + lkc_pkg::CNT_W'(1))
    // After any access the most recent key sits valid in the head cell.
    `ASSERT_NEXT(a_head_valid, i_clk, i_rst_n, w_accept,
                 w_valids[0] && (w_link[1].key == $past(i_req.key)))

endmodule

>>> dv/lkc_result_checker.sv
`timescale 1ns / 1ps

// Watches the access and result channels beside the cache, keeps its own
// recency list of the stored keys and compares every result transfer with the
// oldest prediction still waiting.
module lkc_result_checker #(
    parameter int MAX_ENTRIES = lkc_pkg::DEF_MAX_ENTRIES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lkc_pkg::CNT_W-1:0] i_cfg_wdata,
    lkc_req_if                        i_req,
    lkc_rsp_if                        i_rsp,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_hits,
    output int                        o_evictions
);

    typedef struct packed {
        logic                      hit;
        logic [lkc_pkg::CNT_W-1:0] occupancy;
    } t_access_result;

    // Keys in recency order: index 0 is the most recently used one.
    logic [lkc_pkg::KEY_W-1:0] lru_order[$];
    t_access_result            awaited[$];
    logic [lkc_pkg::CNT_W-1:0] cap_reg;

    // Zero acts as one and anything above the number of cells saturates.
    function automatic int active_capacity(input logic [lkc_pkg::CNT_W-1:0] raw);
        if (raw == '0) return 1;
        if (int'(raw) > MAX_ENTRIES) return MAX_ENTRIES;
        return int'(raw);
    endfunction

    // Applies one access to the recency list and returns what the cache
    // should report for it.
    task automatic predict_access(input logic [lkc_pkg::KEY_W-1:0] key,
                                  output t_access_result res);
        int where_found;
        where_found = -1;
        foreach (lru_order[i]) begin
            if (where_found < 0 && lru_order[i] == key) where_found = i;
        end
        if (where_found >= 0) begin
            lru_order.delete(where_found);
            res.hit = 1'b1;
        end else begin
            // A full store drops its least recently used key first.
            if (lru_order.size() >= active_capacity(cap_reg)) begin
                void'(lru_order.pop_back());
                o_evictions++;
            end
            res.hit = 1'b0;
        end
        lru_order.push_front(key);
        res.occupancy = lkc_pkg::CNT_W'(lru_order.size());
    endtask

    task automatic flag_failure(input string what);
        if (o_fail_count < 10) $display("[%0t] %s", $time, what);
        o_fail_count++;
    endtask

    // Track configuration, predict on each access transfer and check each
    // result transfer.
    always @(posedge i_clk) begin
        t_access_result predicted;
        t_access_result oldest;
        if (!i_rst_n) begin
            lru_order.delete();
            awaited.delete();
            cap_reg      = lkc_pkg::CAP_RESET;
            o_fail_count = 0;
            o_checked    = 0;
            o_hits       = 0;
            o_evictions  = 0;
        end else begin
            // Capacity only changes while the store is empty.
            if (i_cfg_we && lru_order.size() == 0) cap_reg = i_cfg_wdata;

            if (i_req.valid && i_req.ready) begin
                predict_access(i_req.key, predicted);
                awaited.push_back(predicted);
                if (predicted.hit) o_hits++;
            end

            if (i_rsp.valid && i_rsp.ready) begin
                o_checked++;
                if (awaited.size() == 0) begin
                    flag_failure($sformatf(
                        "Result with no access waiting: hit=%0b occupancy=%0d",
                        i_rsp.hit, i_rsp.occupancy));
                end else begin
                    oldest = awaited.pop_front();
                    if (oldest.hit !== i_rsp.hit ||
                        oldest.occupancy !== i_rsp.occupancy) begin
                        flag_failure($sformatf({"Result %0d differs: expected hit=%0b ",
                            "occupancy=%0d, got hit=%0b occupancy=%0d"},
                            o_checked, oldest.hit, oldest.occupancy,
                            i_rsp.hit, i_rsp.occupancy));
                    end
                end
            end
        end
        o_pending = awaited.size();
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

// Drives key accesses into the cache with random gaps and result stalls,
// and leaves prediction and comparison to the result checker.
module tb_top;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 8;
    localparam int PHASES       = 4;
    localparam int PHASE_ITEMS  = 175;
    localparam int SETTLE       = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [lkc_pkg::CNT_W-1:0] i_cfg_wdata;

    bit                        quiet;
    int                        cycle_count;
    int                        fail_count;
    int                        pending;
    int                        checked;
    int                        hits;
    int                        evictions;
    int                        cap_in_use;
    logic [lkc_pkg::KEY_W-1:0] key_pool[$];

    lkc_req_if req_ch ();
    lkc_rsp_if rsp_ch ();

    lru_key_cache dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    lkc_result_checker u_result_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_hits       (hits),
        .o_evictions  (evictions)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: ready drops in random bursts, never in the quiet phase.
    initial begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 6) - 1;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Offers one key and returns at the edge where the transfer happens.
    task automatic send_access(input logic [lkc_pkg::KEY_W-1:0] key);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.key   <= key;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_cap(input logic [lkc_pkg::CNT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Mostly keys from the working set, with some fresh keys, corner
    // patterns and near misses that differ from a stored key in one bit.
    function automatic logic [lkc_pkg::KEY_W-1:0] pick_key();
        logic [lkc_pkg::KEY_W-1:0] corner[4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                                 32'h8000_0000, 32'h7FFF_FFFF};
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return corner[$urandom_range(0, 3)];
            2:       return key_pool[$urandom_range(0, key_pool.size() - 1)]
                            ^ (32'h1 << $urandom_range(0, 31));
            default: return key_pool[$urandom_range(0, key_pool.size() - 1)];
        endcase
    endfunction

    // Main stimulus.
    initial begin
        logic [lkc_pkg::CNT_W-1:0] cap_choices[6];
        logic [lkc_pkg::CNT_W-1:0] final_cap;
        logic [lkc_pkg::CNT_W-1:0] late_cap;
        logic [lkc_pkg::KEY_W-1:0] directed_keys[$];
        int                        pool_size;

        cap_choices  = '{5'd0, 5'd1, 5'd3, 5'd16, 5'd24, 5'd31};
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        req_ch.valid <= 1'b0;
        req_ch.key   <= '0;
        quiet        = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // All of these land on an empty store, so the last one sets the capacity.
        final_cap = cap_choices[$urandom_range(0, 5)];
        write_cap(5'd31);
        write_cap(5'd0);
        write_cap(final_cap);
        i_cfg_we <= 1'b0;
        if (final_cap == 0)
            cap_in_use = 1;
        else if (int'(final_cap) > lkc_pkg::DEF_MAX_ENTRIES)
            cap_in_use = lkc_pkg::DEF_MAX_ENTRIES;
        else
            cap_in_use = int'(final_cap);

        // Directed: corner keys, repeats of older keys and checkerboards.
        directed_keys = '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h0000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                          32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFE, 32'h1234_5678,
                          32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8765_4321,
                          32'h5555_5555, 32'hFEDC_BA98, 32'h8000_0001, 32'hAAAA_AAAA};
        foreach (directed_keys[i]) send_access(directed_keys[i]);
        req_ch.valid <= 1'b0;
        wait_drained();

        // Random phases over a working set a little smaller or larger than
        // the capacity, so hits and evictions both show up.
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                // The store is no longer empty, so these writes must not take.
                if (p == 1)
                    late_cap = 5'd31;
                else if (p == 2)
                    late_cap = 5'd0;
                else
                    late_cap = lkc_pkg::CNT_W'($urandom_range(1, 30));
                write_cap(late_cap);
                i_cfg_we <= 1'b0;
            end
            quiet = (p == PHASES - 1);
            pool_size = cap_in_use + int'($urandom_range(0, 6)) - 2;
            if (pool_size < 1) pool_size = 1;
            key_pool.delete();
            repeat (pool_size) key_pool.push_back($urandom());
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 39) == 0)
                    key_pool[$urandom_range(0, pool_size - 1)] = $urandom();
                send_access(pick_key());
            end
            req_ch.valid <= 1'b0;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d key accesses, %0d hits and %0d evictions at capacity %0d,",
                 checked, hits, evictions, cap_in_use);
        $display("after capacity writes on the empty store and refused writes between phases.");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d results were wrong or unexpected.", fail_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
